/* design/rgb15cc_pkg.sv */
// rgb15cc_pkg: shared types and constants of the 15-bit RGB color converter
// used by the interfaces, the front pipeline, the queue, the back end and the top level
`timescale 1ns / 1ps
`default_nettype none

package rgb15cc_pkg;

   // request kinds carried in req_type
   localparam logic REQ_LOAD  = 1'b0;
   localparam logic REQ_PIXEL = 1'b1;

   // register indexes on the csr channel
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 8;
   localparam logic [CSR_INDEX_W-1:0] CSR_COLOR_MODE     = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_INVERT_RGB     = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SATURATION_PCT = 2'd2;

   // saturation register reset value and upper clamp limit
   localparam logic [7:0] SATURATION_RESET = 8'd100;
   localparam logic [7:0] SATURATION_MAX   = 8'd200;

   // gamma curve geometry and reset clamp limits
   localparam int CURVE_DEPTH = 256;
   localparam logic [7:0] CURVE_LO = 8'd6;
   localparam logic [7:0] CURVE_HI = 8'd247;

   // queue between front and back
   localparam int DEFAULT_QUEUE_DEPTH = 4;

   typedef enum logic [1:0] {
      MODE_COLOR = 2'd0,
      MODE_GREEN = 2'd1,
      MODE_MONO  = 2'd2,
      MODE_AMBER = 2'd3
   } mode_type;

   // settings the back end needs
   typedef struct packed {
      mode_type color_mode;
      logic     invert_rgb;
   } back_cfg_type;

   // one queue entry; a load request carries the curve index in red
   // and the curve value in green
   typedef struct packed {
      logic       is_pixel;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] luma;
   } queue_entry_type;

endpackage

`default_nettype wire

/* design/rgb15cc_ifs.sv */
// rgb15cc_ifs: request, response and csr channel interfaces
// depends on rgb15cc_pkg for the csr field widths
`timescale 1ns / 1ps
`default_nettype none

interface rgb15cc_req_if;
   logic        valid;
   logic        ready;
   logic        req_type;
   logic [14:0] pixel_rgb;
   logic [7:0]  curve_index;
   logic [7:0]  curve_value;

   modport source (output valid, req_type, pixel_rgb, curve_index, curve_value,
                   input ready);
   modport sink   (input valid, req_type, pixel_rgb, curve_index, curve_value,
                   output ready);
endinterface

interface rgb15cc_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] pixel_565;
   logic [23:0] pixel_888;

   modport source (output valid, pixel_565, pixel_888, input ready);
   modport sink   (input valid, pixel_565, pixel_888, output ready);
endinterface

interface rgb15cc_csr_if import rgb15cc_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* design/rgb15cc_front.sv */
// rgb15cc_front: accepts requests, computes luma and the saturation stage
// depends on rgb15cc_pkg and rgb15cc_req_if; feeds rgb15cc_queue
`timescale 1ns / 1ps
`default_nettype none

module rgb15cc_front import rgb15cc_pkg::*; (
   input  wire logic            clock,
   input  wire logic            reset,
   rgb15cc_req_if.sink          req_port,
   input  wire logic [7:0]      saturation_pct,
   output queue_entry_type      push_data,
   output logic                 push_valid,
   input  wire logic            push_ready
);

   // q16 luma weights and chroma weights for green
   localparam logic [23:0] LUMA_WR = 24'd19589;
   localparam logic [23:0] LUMA_WG = 24'd38443;
   localparam logic [23:0] LUMA_WB = 24'd7504;
   localparam logic signed [25:0] GREEN_WCB = 26'sd12792;
   localparam logic signed [25:0] GREEN_WCR = 26'sd33394;
   // x / 100 == (x * 83887) >> 23 for x below 91180
   localparam logic [32:0] PCT_RECIP = 33'd83887;
   localparam int PCT_SHIFT = 23;

   // clamp a signed level to 0..255
   function automatic logic [7:0] clamp_level(input logic signed [10:0] v);
      logic [7:0] res;
      if (v < 0)
         res = 8'd0;
      else if (v > 11'sd255)
         res = 8'd255;
      else
         res = v[7:0];
      return res;
   endfunction

   // apply sign and clamp a chroma magnitude to -256..255
   function automatic logic signed [8:0] clamp_chroma(input logic neg, input logic [8:0] mag);
      logic signed [8:0] res;
      if (!neg)
         res = (mag > 9'd255) ? 9'sd255 : $signed(mag);
      else
         res = (mag > 9'd256) ? -9'sd256 : $signed(9'd0 - mag);
      return res;
   endfunction

   logic front_en;
   logic [7:0] pct_eff;
   logic       bypass;

   // stage 1: captured request
   logic       s1_valid_ff, s1_pixel_ff;
   logic [7:0] s1_red_ff, s1_green_ff, s1_blue_ff;
   logic [7:0] s1_red_in, s1_green_in, s1_blue_in;

   // stage 2: luma
   logic        s2_valid_ff, s2_pixel_ff;
   logic [7:0]  s2_red_ff, s2_green_ff, s2_blue_ff, s2_luma_ff;
   logic [23:0] luma_sum;
   logic [7:0]  s2_luma_in;

   // stage 3: scaled chroma magnitudes
   logic        s3_valid_ff, s3_pixel_ff;
   logic [7:0]  s3_red_ff, s3_green_ff, s3_blue_ff, s3_luma_ff;
   logic        s3_cb_neg_ff, s3_cr_neg_ff;
   logic [15:0] s3_cb_prod_ff, s3_cr_prod_ff;
   logic        s3_cb_neg_in, s3_cr_neg_in;
   logic [15:0] s3_cb_prod_in, s3_cr_prod_in;
   logic [9:0]  cb_diff, cr_diff;
   logic [8:0]  cb_mag, cr_mag;
   logic [16:0] cb_prod, cr_prod;

   // stage 4: quotients by 100
   logic        s4_valid_ff, s4_pixel_ff;
   logic [7:0]  s4_red_ff, s4_green_ff, s4_blue_ff, s4_luma_ff;
   logic        s4_cb_neg_ff, s4_cr_neg_ff;
   logic [8:0]  s4_cb_quo_ff, s4_cr_quo_ff;
   logic [32:0] cb_mul, cr_mul;

   // stage 5: recombined red, blue and green products
   logic               s5_valid_ff, s5_pixel_ff;
   logic [7:0]         s5_red_ff, s5_green_ff, s5_blue_ff, s5_luma_ff;
   logic signed [10:0] s5_rsum_ff, s5_bsum_ff;
   logic signed [25:0] s5_pcb_ff, s5_pcr_ff;
   logic signed [8:0]  cb_clamped, cr_clamped;
   logic signed [10:0] s5_rsum_in, s5_bsum_in;
   logic signed [25:0] s5_pcb_in, s5_pcr_in;

   // stage 6: final levels ready for the queue
   logic               s6_valid_ff;
   queue_entry_type    s6_entry_ff, s6_entry_in;
   logic signed [26:0] green_total;
   logic signed [10:0] green_quo;

   // effective saturation
   always_comb begin
      pct_eff = (saturation_pct > SATURATION_MAX) ? SATURATION_MAX : saturation_pct;
      bypass  = (saturation_pct == SATURATION_RESET);
   end

   // whole pipeline holds while the last stage cannot hand over
   always_comb begin
      front_en       = !(s6_valid_ff && !push_ready);
      req_port.ready = front_en;
      push_valid     = s6_valid_ff;
      push_data      = s6_entry_ff;
   end

   // stage 1 inputs: channels scaled by 8, or the load fields
   always_comb begin
      if (req_port.req_type == REQ_PIXEL) begin
         s1_red_in   = {req_port.pixel_rgb[14:10], 3'b000};
         s1_green_in = {req_port.pixel_rgb[9:5], 3'b000};
      end else begin
         s1_red_in   = req_port.curve_index;
         s1_green_in = req_port.curve_value;
      end
      s1_blue_in = {req_port.pixel_rgb[4:0], 3'b000};
   end

   // stage 2 luma
   always_comb begin
      luma_sum = LUMA_WR * {16'd0, s1_red_ff} + LUMA_WG * {16'd0, s1_green_ff}
               + LUMA_WB * {16'd0, s1_blue_ff};
      s2_luma_in = luma_sum[23:16];
   end

   // stage 3 chroma differences times percentage
   always_comb begin
      cb_diff = {2'b00, s2_blue_ff} - {2'b00, s2_luma_ff};
      cr_diff = {2'b00, s2_red_ff} - {2'b00, s2_luma_ff};
      s3_cb_neg_in = cb_diff[9];
      s3_cr_neg_in = cr_diff[9];
      cb_mag = cb_diff[9] ? 9'(10'd0 - cb_diff) : cb_diff[8:0];
      cr_mag = cr_diff[9] ? 9'(10'd0 - cr_diff) : cr_diff[8:0];
      cb_prod = {8'd0, cb_mag} * {9'd0, pct_eff};
      cr_prod = {8'd0, cr_mag} * {9'd0, pct_eff};
      // magnitudes stay below 248 * 200
      s3_cb_prod_in = cb_prod[15:0];
      s3_cr_prod_in = cr_prod[15:0];
   end

   // stage 4 divide by 100 through the reciprocal
   always_comb begin
      cb_mul = {17'd0, s3_cb_prod_ff} * PCT_RECIP;
      cr_mul = {17'd0, s3_cr_prod_ff} * PCT_RECIP;
   end

   // stage 5 clamp chroma, form red, blue and the green terms
   always_comb begin
      cb_clamped = clamp_chroma(s4_cb_neg_ff, s4_cb_quo_ff);
      cr_clamped = clamp_chroma(s4_cr_neg_ff, s4_cr_quo_ff);
      s5_rsum_in = 11'(cr_clamped) + $signed({3'b000, s4_luma_ff});
      s5_bsum_in = 11'(cb_clamped) + $signed({3'b000, s4_luma_ff});
      s5_pcb_in  = 26'(cb_clamped) * GREEN_WCB;
      s5_pcr_in  = 26'(cr_clamped) * GREEN_WCR;
   end

   // stage 6 green with truncation toward zero, clamps and bypass
   always_comb begin
      green_total = $signed({3'b000, s5_luma_ff, 16'd0}) - 27'(s5_pcb_ff) - 27'(s5_pcr_ff);
      green_quo   = green_total[26:16];
      if (green_total[26] && (green_total[15:0] != 16'd0))
         green_quo = green_quo + 11'sd1;
      s6_entry_in.is_pixel = s5_pixel_ff;
      s6_entry_in.luma     = s5_luma_ff;
      if (!s5_pixel_ff || bypass) begin
         s6_entry_in.red   = s5_red_ff;
         s6_entry_in.green = s5_green_ff;
         s6_entry_in.blue  = s5_blue_ff;
      end else begin
         s6_entry_in.red   = clamp_level(s5_rsum_ff);
         s6_entry_in.green = clamp_level(green_quo);
         s6_entry_in.blue  = clamp_level(s5_bsum_ff);
      end
   end

   // stage valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
         s6_valid_ff <= 1'b0;
      end else if (front_en) begin
         s1_valid_ff <= req_port.valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
         s5_valid_ff <= s4_valid_ff;
         s6_valid_ff <= s5_valid_ff;
      end
   end

   // stage payloads
   always_ff @(posedge clock) begin
      if (front_en) begin
         s1_pixel_ff <= (req_port.req_type == REQ_PIXEL);
         s1_red_ff   <= s1_red_in;
         s1_green_ff <= s1_green_in;
         s1_blue_ff  <= s1_blue_in;

         s2_pixel_ff <= s1_pixel_ff;
         s2_red_ff   <= s1_red_ff;
         s2_green_ff <= s1_green_ff;
         s2_blue_ff  <= s1_blue_ff;
         s2_luma_ff  <= s2_luma_in;

         s3_pixel_ff   <= s2_pixel_ff;
         s3_red_ff     <= s2_red_ff;
         s3_green_ff   <= s2_green_ff;
         s3_blue_ff    <= s2_blue_ff;
         s3_luma_ff    <= s2_luma_ff;
         s3_cb_neg_ff  <= s3_cb_neg_in;
         s3_cr_neg_ff  <= s3_cr_neg_in;
         s3_cb_prod_ff <= s3_cb_prod_in;
         s3_cr_prod_ff <= s3_cr_prod_in;

         s4_pixel_ff  <= s3_pixel_ff;
         s4_red_ff    <= s3_red_ff;
         s4_green_ff  <= s3_green_ff;
         s4_blue_ff   <= s3_blue_ff;
         s4_luma_ff   <= s3_luma_ff;
         s4_cb_neg_ff <= s3_cb_neg_ff;
         s4_cr_neg_ff <= s3_cr_neg_ff;
         s4_cb_quo_ff <= cb_mul[PCT_SHIFT+8:PCT_SHIFT];
         s4_cr_quo_ff <= cr_mul[PCT_SHIFT+8:PCT_SHIFT];

         s5_pixel_ff <= s4_pixel_ff;
         s5_red_ff   <= s4_red_ff;
         s5_green_ff <= s4_green_ff;
         s5_blue_ff  <= s4_blue_ff;
         s5_luma_ff  <= s4_luma_ff;
         s5_rsum_ff  <= s5_rsum_in;
         s5_bsum_ff  <= s5_bsum_in;
         s5_pcb_ff   <= s5_pcb_in;
         s5_pcr_ff   <= s5_pcr_in;

         s6_entry_ff <= s6_entry_in;
      end
   end

endmodule

`default_nettype wire

/* design/rgb15cc_queue.sv */
// rgb15cc_queue: small first-in first-out queue between front and back
// depends on rgb15cc_pkg for the entry type
`timescale 1ns / 1ps
`default_nettype none

module rgb15cc_queue import rgb15cc_pkg::*; #(
   parameter int DEPTH = DEFAULT_QUEUE_DEPTH
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            push_valid,
   output logic                 push_ready,
   input  wire queue_entry_type push_data,
   output logic                 pop_valid,
   input  wire logic            pop_ready,
   output queue_entry_type      pop_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   queue_entry_type slots [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic push, pop;

   // handshake and pointer updates
   always_comb begin
      push_ready = (count_ff != CNT_FULL);
      pop_valid  = (count_ff != '0);
      pop_data   = slots[rd_ptr_ff];
      push = push_valid && push_ready;
      pop  = pop_valid && pop_ready;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push)
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      if (pop)
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      if (push && !pop)
         count_in = count_ff + 1'b1;
      else if (pop && !push)
         count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push)
         slots[wr_ptr_ff] <= push_data;
   end

endmodule

`default_nettype wire

/* design/rgb15cc_back.sv */
// rgb15cc_back: gamma curve lookup, monitor mode formatting, response register
// depends on rgb15cc_pkg and rgb15cc_rsp_if; drains rgb15cc_queue
`timescale 1ns / 1ps
`default_nettype none

module rgb15cc_back import rgb15cc_pkg::*; (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            pop_valid,
   output logic                 pop_ready,
   input  wire queue_entry_type pop_data,
   input  wire back_cfg_type    cfg,
   rgb15cc_rsp_if.source        rsp_port
);

   localparam int LANES = 4;
   localparam int ADDR_W = $clog2(CURVE_DEPTH);
   localparam logic [7:0]  AMBER_NUM = 8'd176;
   // x / 255 == (x * 32897) >> 23 for x below 66052
   localparam logic [31:0] AMBER_RECIP = 32'd32897;
   localparam int AMBER_SHIFT = 23;

   // reset contents of the curve: identity clamped
   function automatic logic [7:0] curve_default(input logic [ADDR_W-1:0] a);
      logic [7:0] res;
      if (a < CURVE_LO)
         res = CURVE_LO;
      else if (a > CURVE_HI)
         res = CURVE_HI;
      else
         res = 8'(a);
      return res;
   endfunction

   logic back_en, pop, load;
   logic [ADDR_W-1:0] rd_addr [LANES];
   logic [CURVE_DEPTH-1:0] curve_vld_ff;

   // read stage
   logic       b1_valid_ff;
   logic [7:0] rd_q_ff   [LANES];
   logic       vld_q_ff  [LANES];
   logic [7:0] dflt_q_ff [LANES];
   logic [7:0] level     [LANES];

   // level stage
   logic        b2_valid_ff;
   logic [7:0]  b2_red_ff, b2_green_ff, b2_blue_ff, b2_luma_ff;
   logic [15:0] b2_aprod_ff, b2_aprod_in;

   // response register
   logic        b3_valid_ff;
   logic [15:0] o565_ff, o565_in;
   logic [23:0] o888_ff, o888_in;
   logic [31:0] amber_mul;
   logic [7:0]  amber;

   // stall only when the response is held
   always_comb begin
      back_en   = !(b3_valid_ff && !rsp_port.ready);
      pop_ready = back_en;
      pop  = pop_valid && back_en;
      load = pop && !pop_data.is_pixel;
      // lanes: red, green, blue, luma
      rd_addr[0] = pop_data.red;
      rd_addr[1] = pop_data.green;
      rd_addr[2] = pop_data.blue;
      rd_addr[3] = pop_data.luma;
   end

   // one copy of the curve per lane, all written by load requests
   for (genvar k = 0; k < LANES; k++) begin : g_lane
      logic [7:0] curve_mem [CURVE_DEPTH];

      always_ff @(posedge clock) begin
         if (load)
            curve_mem[pop_data.red] <= pop_data.green;
      end

      always_ff @(posedge clock) begin
         if (back_en) begin
            rd_q_ff[k]   <= curve_mem[rd_addr[k]];
            vld_q_ff[k]  <= curve_vld_ff[rd_addr[k]];
            dflt_q_ff[k] <= curve_default(rd_addr[k]);
         end
      end

      // entries never loaded read as their reset value
      always_comb begin
         level[k] = vld_q_ff[k] ? rd_q_ff[k] : dflt_q_ff[k];
      end
   end

   // written flags of the curve entries
   always_ff @(posedge clock) begin
      if (reset)
         curve_vld_ff <= '0;
      else if (load)
         curve_vld_ff[pop_data.red] <= 1'b1;
   end

   // amber level, first the product
   always_comb begin
      b2_aprod_in = {8'd0, level[3]} * {8'd0, AMBER_NUM};
   end

   // amber divide and mode formatting
   always_comb begin
      amber_mul = {16'd0, b2_aprod_ff} * AMBER_RECIP;
      amber     = amber_mul[AMBER_SHIFT+7:AMBER_SHIFT];
      case (cfg.color_mode)
         MODE_GREEN: begin
            o888_in = {8'h10, b2_luma_ff, 8'h10};
            o565_in = {5'b00001, b2_luma_ff[7:2], 5'b00001};
         end
         MODE_MONO: begin
            o888_in = {b2_luma_ff, b2_luma_ff, b2_luma_ff};
            o565_in = {b2_luma_ff[7:3], b2_luma_ff[7:2], b2_luma_ff[7:3]};
         end
         MODE_AMBER: begin
            o888_in = cfg.invert_rgb ? {8'd0, amber, b2_luma_ff}
                                     : {b2_luma_ff, amber, 8'd0};
            o565_in = {b2_luma_ff[7:3], amber[7:2], 5'd0};
         end
         default: begin
            o888_in = cfg.invert_rgb ? {b2_blue_ff, b2_green_ff, b2_red_ff}
                                     : {b2_red_ff, b2_green_ff, b2_blue_ff};
            o565_in = {b2_red_ff[7:3], b2_green_ff[7:2], b2_blue_ff[7:3]};
         end
      endcase
   end

   // stage valid bits; load requests leave no result
   always_ff @(posedge clock) begin
      if (reset) begin
         b1_valid_ff <= 1'b0;
         b2_valid_ff <= 1'b0;
         b3_valid_ff <= 1'b0;
      end else if (back_en) begin
         b1_valid_ff <= pop && pop_data.is_pixel;
         b2_valid_ff <= b1_valid_ff;
         b3_valid_ff <= b2_valid_ff;
      end
   end

   // stage payloads
   always_ff @(posedge clock) begin
      if (back_en) begin
         b2_red_ff   <= level[0];
         b2_green_ff <= level[1];
         b2_blue_ff  <= level[2];
         b2_luma_ff  <= level[3];
         b2_aprod_ff <= b2_aprod_in;
         o565_ff     <= o565_in;
         o888_ff     <= o888_in;
      end
   end

   // response channel
   always_comb begin
      rsp_port.valid     = b3_valid_ff;
      rsp_port.pixel_565 = o565_ff;
      rsp_port.pixel_888 = o888_ff;
   end

endmodule

`default_nettype wire

/* design/rgb15_monitor_color_convert.sv */
// rgb15_monitor_color_convert: 15-bit RGB pixel converter with a loadable gamma curve.
//
// Channels: req_port takes requests, either a pixel to convert (req_type 1) or
// one gamma curve entry to load (req_type 0); rsp_port returns pixel_565 and
// pixel_888 for each pixel request, nothing for a load request; csr_port
// writes color_mode (index 0), invert_rgb (index 1) and saturation_pct
// (index 2) and is always ready. Registers must be changed only while idle;
// the block does not enforce it. Throughput: one request per clock while
// nothing stalls. A six-stage front pipeline computes luma and the
// saturation stage, a queue decouples it from a three-stage back end that
// looks the four levels up in four copies of the gamma curve and formats the
// mode; a response passes the front stages, a queue slot and the back end.
// Reset: registers return to color mode, no swap, 100 percent saturation;
// the curve reads as identity clamped to 6..247 until entries are loaded.
// Stalls: when rsp_port is not ready the back end holds, the queue fills and
// then the front pipeline holds and req_port drops ready.
// depends on rgb15cc_pkg, rgb15cc_ifs, rgb15cc_front, rgb15cc_queue, rgb15cc_back
`timescale 1ns / 1ps
`default_nettype none

module rgb15_monitor_color_convert import rgb15cc_pkg::*; #(
   parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
) (
   input  wire logic     clock,
   input  wire logic     reset,
   rgb15cc_req_if.sink   req_port,
   rgb15cc_rsp_if.source rsp_port,
   rgb15cc_csr_if.sink   csr_port
);

   mode_type   color_mode_ff;
   logic       invert_rgb_ff;
   logic [7:0] saturation_pct_ff;
   back_cfg_type back_cfg;

   queue_entry_type push_data, pop_data;
   logic push_valid, push_ready, pop_valid, pop_ready;

   // configuration registers
   always_comb begin
      csr_port.ready      = 1'b1;
      back_cfg.color_mode = color_mode_ff;
      back_cfg.invert_rgb = invert_rgb_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         color_mode_ff     <= MODE_COLOR;
         invert_rgb_ff     <= 1'b0;
         saturation_pct_ff <= SATURATION_RESET;
      end else if (csr_port.valid) begin
         case (csr_port.index)
            CSR_COLOR_MODE:     color_mode_ff     <= mode_type'(csr_port.data[1:0]);
            CSR_INVERT_RGB:     invert_rgb_ff     <= csr_port.data[0];
            CSR_SATURATION_PCT: saturation_pct_ff <= csr_port.data;
            default: ;
         endcase
      end
   end

   // luma and saturation pipeline
   rgb15cc_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_port       (req_port),
      .saturation_pct (saturation_pct_ff),
      .push_data      (push_data),
      .push_valid     (push_valid),
      .push_ready     (push_ready)
   );

   // decoupling queue
   rgb15cc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   // gamma lookup and output formatting
   rgb15cc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_data  (pop_data),
      .cfg       (back_cfg),
      .rsp_port  (rsp_port)
   );

endmodule

`default_nettype wire
